@@ hw/rtl/modbus_rtu_response_deframer_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU response deframer
// Concurrent checks, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_DEFRAMER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_DEFRAMER_DEFINES_SVH

// Same-cycle implication
`define MRD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication
`define MRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ hw/rtl/mrd_pkg.sv @@
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared constants, codes, control structs and the CRC16 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

    localparam int RING_DEPTH_DEF  = 512;
    localparam int IMAGE_WORDS_DEF = 128;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int LEN_W      = 9;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int WIDX_W     = 7;
    localparam int WML_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FRAME = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DATA  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WML        = 2'd1;

    // Function codes
    localparam logic [BYTE_W-1:0] FUNC_READ_HOLD   = 8'd3;
    localparam logic [BYTE_W-1:0] FUNC_WRITE_ONE   = 8'd6;
    localparam logic [BYTE_W-1:0] FUNC_WRITE_MULTI = 8'd16;

    localparam logic [LEN_W-1:0] LEN_FUNC3_EXTRA = 9'd5;
    localparam logic [LEN_W-1:0] LEN_FUNC6       = 9'd8;
    localparam logic [LEN_W-1:0] LEN_CRC_BYTES   = 9'd2;
    localparam logic [WML_W-1:0] WML_MIN         = 5'd8;
    localparam logic [WML_W-1:0] WML_MAX         = 5'd16;
    localparam int               MIN_SCAN_FILL   = 6;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic              init;
        logic              step;
        logic [BYTE_W-1:0] data;
    } t_crc_ctrl;

    typedef struct packed {
        logic              we;
        logic [WIDX_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_img_wr;

    // Fold one byte into the reflected Modbus CRC16
    function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc_in,
                                                     input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < BYTE_W; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mrd_ring.sv @@
// ----------------------------------------------------------------------------
// mrd_ring
// Byte ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_ring #(
    parameter int RING_DEPTH = mrd_pkg::RING_DEPTH_DEF,
    parameter int PW         = $clog2(RING_DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [PW-1:0]             i_waddr,
    input  wire logic [mrd_pkg::BYTE_W-1:0] i_wdata,
    input  wire logic [PW-1:0]             i_raddr,
    output logic      [mrd_pkg::BYTE_W-1:0] o_rdata
);
    import mrd_pkg::*;

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Write on request, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/mrd_crc.sv @@
// ----------------------------------------------------------------------------
// mrd_crc
// Shared CRC16 accumulator, one byte folded per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_crc (
    input  wire logic                       i_clk,
    input  wire mrd_pkg::t_crc_ctrl         i_ctrl,
    output logic      [mrd_pkg::WORD_W-1:0] o_crc
);
    import mrd_pkg::*;

    logic [WORD_W-1:0] r_crc;

    // Seed or fold one byte
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_crc <= CRC_INIT;
        end else if (i_ctrl.step) begin
            r_crc <= crc16_byte(r_crc, i_ctrl.data);
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

@@ hw/rtl/mrd_image.sv @@
// ----------------------------------------------------------------------------
// mrd_image
// Register image memory; per-word valid bits make unwritten words read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_image #(
    parameter int IMAGE_WORDS = mrd_pkg::IMAGE_WORDS_DEF,
    parameter int IW          = $clog2(IMAGE_WORDS)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mrd_pkg::t_img_wr           i_wr,
    input  wire logic [mrd_pkg::WIDX_W-1:0] i_raddr,
    output logic      [mrd_pkg::WORD_W-1:0] o_rdata
);
    import mrd_pkg::*;

    logic [WORD_W-1:0]      r_mem [IMAGE_WORDS];
    logic [IMAGE_WORDS-1:0] r_valid;
    logic [WORD_W-1:0]      r_rdata;
    logic                   r_hit;
    logic                   wr_ok;
    logic                   rd_ok;
    logic [IW-1:0]          wr_idx;
    logic [IW-1:0]          rd_idx;

    assign wr_idx = i_wr.addr[IW-1:0];
    assign rd_idx = i_raddr[IW-1:0];
    assign wr_ok  = i_wr.we && (32'(i_wr.addr) < 32'(IMAGE_WORDS));
    assign rd_ok  = 32'(i_raddr) < 32'(IMAGE_WORDS);

    // Mark written words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_ok) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // Word storage and registered read
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_idx] <= i_wr.data;
        end
        r_rdata <= r_mem[rd_idx];
        r_hit   <= rd_ok && r_valid[rd_idx];
    end

    assign o_rdata = r_hit ? r_rdata : '0;

endmodule

`default_nettype wire

@@ hw/rtl/modbus_rtu_response_deframer.sv @@
// Steps: a store or unused command goes from ST_IDLE to ST_EMIT; an image read passes ST_IMG.
// Scan: ST_CHECK and ST_HDR0..ST_HDR3 per header looked at, ST_CRC0, ST_CRC and ST_CMP_LO/HI
// per CRC check, ST_CP_HI/ST_CP_LO per payload word copied; one ring byte per cycle
// through the single read port into the byte-wide CRC unit. A new item is taken only once
// the previous one is done. Reset (synchronous, active low) clears pointers, image valid
// bits, state, output-valid and config registers; ring contents stay undefined, need no clearing.
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer
// Byte ring with a frame scanner, CRC16 check and register image loader.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_deframer #(
    parameter int RING_DEPTH  = mrd_pkg::RING_DEPTH_DEF,
    parameter int IMAGE_WORDS = mrd_pkg::IMAGE_WORDS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input items
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [mrd_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [mrd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  wire logic [mrd_pkg::WIDX_W-1:0]     i_word_index,
    // Result items
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [mrd_pkg::STAT_W-1:0]     o_status,
    output logic      [mrd_pkg::BYTE_W-1:0]     o_function_code,
    output logic      [mrd_pkg::BYTE_W-1:0]     o_payload_bytes,
    output logic      [mrd_pkg::WORD_W-1:0]     o_read_word,
    // Configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mrd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mrd_pkg::*;

    `include "modbus_rtu_response_deframer_defines.svh"

    localparam int PW = $clog2(RING_DEPTH);
    localparam int AW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam logic [AW-1:0] DEPTH_A    = AW'(RING_DEPTH);
    localparam logic [AW-1:0] DEPTH_M1_A = AW'(RING_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_F    = (PW+1)'(RING_DEPTH);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_CHECK  = 14'b00000000000010,
        ST_HDR0   = 14'b00000000000100,
        ST_HDR1   = 14'b00000000001000,
        ST_HDR2   = 14'b00000000010000,
        ST_HDR3   = 14'b00000000100000,
        ST_CRC0   = 14'b00000001000000,
        ST_CRC    = 14'b00000010000000,
        ST_CMP_LO = 14'b00000100000000,
        ST_CMP_HI = 14'b00001000000000,
        ST_CP_HI  = 14'b00010000000000,
        ST_CP_LO  = 14'b00100000000000,
        ST_IMG    = 14'b01000000000000,
        ST_EMIT   = 14'b10000000000000
    } t_state;

    // Ring position plus offset, wrapped once
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p,
                                               input logic [LEN_W-1:0] n);
        logic [AW-1:0] s;
        s = AW'(p) + AW'(n);
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[PW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [PW-1:0]       r_rp, n_rp;
    logic [PW-1:0]       r_wp, n_wp;
    logic [LEN_W-1:0]    r_off, n_off;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [BYTE_W-1:0]   r_addr_b, n_addr_b;
    logic [BYTE_W-1:0]   r_func, n_func;
    logic [BYTE_W-1:0]   r_count, n_count;
    logic [BYTE_W-1:0]   r_hi, n_hi;
    logic                r_lo_ok, n_lo_ok;
    logic [WIDX_W-1:0]   r_w, n_w;
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic [BYTE_W-1:0]   r_res_func, n_res_func;
    logic [BYTE_W-1:0]   r_res_pay, n_res_pay;
    logic [WORD_W-1:0]   r_res_word, n_res_word;
    logic [BYTE_W-1:0]   r_slave;
    logic [WML_W-1:0]    r_wml;
    logic                r_ovalid;
    logic [STAT_W-1:0]   r_ostatus;
    logic [BYTE_W-1:0]   r_ofunc;
    logic [BYTE_W-1:0]   r_opay;
    logic [WORD_W-1:0]   r_oword;

    logic                in_acc;
    logic                out_free;
    logic                emit;
    logic [PW:0]         fill;
    logic                ring_full;
    logic                ring_we;
    logic [PW-1:0]       ring_raddr;
    logic [BYTE_W-1:0]   rd_byte;
    logic [WORD_W-1:0]   crc;
    logic [WORD_W-1:0]   img_rdata;
    t_crc_ctrl           crc_ctrl;
    t_img_wr             img_wr;
    logic                func_ok;
    logic [WML_W-1:0]    wml_c;
    logic [LEN_W-1:0]    hdr_len;
    logic [BYTE_W-1:0]   half_count;
    logic                out_func_known;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign emit       = (r_state == ST_EMIT) && out_free;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Ring fill level
    always_comb begin
        if (r_wp >= r_rp) begin
            fill = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            fill = {1'b0, r_wp} + DEPTH_F - {1'b0, r_rp};
        end
    end
    assign ring_full  = AW'(fill) >= DEPTH_M1_A;
    assign ring_we    = in_acc && (i_cmd == CMD_STORE) && !ring_full;
    assign ring_raddr = ring_add(r_rp, r_off);

    // Frame length from the header
    assign func_ok = (r_func == FUNC_READ_HOLD) || (r_func == FUNC_WRITE_ONE) ||
                     (r_func == FUNC_WRITE_MULTI);
    always_comb begin
        if (r_wml < WML_MIN) begin
            wml_c = WML_MIN;
        end else if (r_wml > WML_MAX) begin
            wml_c = WML_MAX;
        end else begin
            wml_c = r_wml;
        end
        if (r_func == FUNC_READ_HOLD) begin
            hdr_len = {1'b0, rd_byte} + LEN_FUNC3_EXTRA;
        end else if (r_func == FUNC_WRITE_ONE) begin
            hdr_len = LEN_FUNC6;
        end else begin
            hdr_len = {{(LEN_W-WML_W){1'b0}}, wml_c};
        end
    end
    assign half_count = {1'b0, r_count[BYTE_W-1:1]};

    // CRC unit and image write controls
    always_comb begin
        crc_ctrl.init = (r_state == ST_CRC0);
        crc_ctrl.step = (r_state == ST_CRC);
        crc_ctrl.data = rd_byte;
        img_wr.we     = (r_state == ST_CP_LO);
        img_wr.addr   = r_w;
        img_wr.data   = {r_hi, rd_byte};
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_off        = r_off;
        n_len        = r_len;
        n_addr_b     = r_addr_b;
        n_func       = r_func;
        n_count      = r_count;
        n_hi         = r_hi;
        n_lo_ok      = r_lo_ok;
        n_w          = r_w;
        n_res_status = r_res_status;
        n_res_func   = r_res_func;
        n_res_pay    = r_res_pay;
        n_res_word   = r_res_word;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res_status = STAT_NONE;
                    n_res_func   = '0;
                    n_res_pay    = '0;
                    n_res_word   = '0;
                    unique case (i_cmd)
                        CMD_STORE: begin
                            if (ring_full) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                n_wp = ring_add(r_wp, LEN_W'(1));
                            end
                            n_state = ST_EMIT;
                        end
                        CMD_SCAN: n_state = ST_CHECK;
                        CMD_READ: n_state = ST_IMG;
                        CMD_NONE: n_state = ST_EMIT;
                        default:  n_state = ST_EMIT;
                    endcase
                end
            end
            ST_CHECK: begin
                n_off = '0;
                if (AW'(fill) < AW'(MIN_SCAN_FILL)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_HDR0;
                end
            end
            ST_HDR0: begin
                n_off   = LEN_W'(1);
                n_state = ST_HDR1;
            end
            ST_HDR1: begin
                n_addr_b = rd_byte;
                n_off    = LEN_W'(2);
                n_state  = ST_HDR2;
            end
            ST_HDR2: begin
                n_func  = rd_byte;
                n_off   = LEN_W'(3);
                n_state = ST_HDR3;
            end
            ST_HDR3: begin
                n_count = rd_byte;
                n_len   = hdr_len;
                if ((r_addr_b != r_slave) || !func_ok || (AW'(hdr_len) > DEPTH_M1_A)) begin
                    // drop one byte and rescan
                    n_rp    = ring_add(r_rp, LEN_W'(1));
                    n_state = ST_CHECK;
                end else if (AW'(fill) < AW'(hdr_len)) begin
                    // frame incomplete: stop and keep the read pointer
                    n_state = ST_EMIT;
                end else begin
                    n_off   = '0;
                    n_state = ST_CRC0;
                end
            end
            ST_CRC0: begin
                n_off   = LEN_W'(1);
                n_state = ST_CRC;
            end
            ST_CRC: begin
                n_off = r_off + LEN_W'(1);
                if (r_off == (r_len - LEN_CRC_BYTES)) begin
                    n_state = ST_CMP_LO;
                end
            end
            ST_CMP_LO: begin
                n_lo_ok = (rd_byte == crc[7:0]);
                n_off   = LEN_W'(3);
                n_state = ST_CMP_HI;
            end
            ST_CMP_HI: begin
                if (r_lo_ok && (rd_byte == crc[15:8])) begin
                    n_res_status = STAT_FRAME;
                    n_res_func   = r_func;
                    if (r_func == FUNC_READ_HOLD) begin
                        n_res_pay = r_count;
                    end
                    if ((r_func == FUNC_READ_HOLD) && (half_count != '0)) begin
                        n_off   = LEN_W'(4);
                        n_w     = '0;
                        n_state = ST_CP_HI;
                    end else begin
                        n_rp    = ring_add(r_rp, r_len);
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_rp    = ring_add(r_rp, LEN_W'(1));
                    n_state = ST_CHECK;
                end
            end
            ST_CP_HI: begin
                n_hi    = rd_byte;
                n_off   = r_off + LEN_W'(1);
                n_state = ST_CP_LO;
            end
            ST_CP_LO: begin
                n_w   = r_w + WIDX_W'(1);
                n_off = r_off + LEN_W'(1);
                if ({1'b0, r_w} == (half_count - BYTE_W'(1))) begin
                    n_rp    = ring_add(r_rp, r_len);
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_CP_HI;
                end
            end
            ST_IMG: begin
                n_res_status = STAT_DATA;
                n_res_word   = img_rdata;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
            r_slave  <= 8'd1;
            r_wml    <= WML_MIN;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SLAVE_ADDR: r_slave <= i_cfg_data;
                    CFG_WML:        r_wml   <= i_cfg_data[WML_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_off        <= n_off;
        r_len        <= n_len;
        r_addr_b     <= n_addr_b;
        r_func       <= n_func;
        r_count      <= n_count;
        r_hi         <= n_hi;
        r_lo_ok      <= n_lo_ok;
        r_w          <= n_w;
        r_res_status <= n_res_status;
        r_res_func   <= n_res_func;
        r_res_pay    <= n_res_pay;
        r_res_word   <= n_res_word;
        if (emit) begin
            r_ostatus <= r_res_status;
            r_ofunc   <= r_res_func;
            r_opay    <= r_res_pay;
            r_oword   <= r_res_word;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_function_code = r_ofunc;
    assign o_payload_bytes = r_opay;
    assign o_read_word     = r_oword;

    mrd_ring #(
        .RING_DEPTH (RING_DEPTH),
        .PW         (PW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (i_rx_byte),
        .i_raddr (ring_raddr),
        .o_rdata (rd_byte)
    );

    mrd_crc u_crc (
        .i_clk  (i_clk),
        .i_ctrl (crc_ctrl),
        .o_crc  (crc)
    );

    mrd_image #(
        .IMAGE_WORDS (IMAGE_WORDS)
    ) u_image (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (img_wr),
        .i_raddr (i_word_index),
        .o_rdata (img_rdata)
    );

    // Checks
    assign out_func_known = (o_function_code == FUNC_READ_HOLD) ||
                            (o_function_code == FUNC_WRITE_ONE) ||
                            (o_function_code == FUNC_WRITE_MULTI);

    `MRD_ASSERT_IMPL(a_crc_in_frame, r_state == ST_CRC, r_off <= (r_len - LEN_CRC_BYTES))
    `MRD_ASSERT_IMPL(a_img_idx_in_count, img_wr.we, {1'b0, r_w} < half_count)
    `MRD_ASSERT_IMPL(a_frame_func, o_out_valid && (o_status == STAT_FRAME), out_func_known)
    `MRD_ASSERT_IMPL(a_pay_only_read, o_out_valid && |o_payload_bytes, o_function_code == FUNC_READ_HOLD)
    `MRD_ASSERT_NEXT(a_store_advances, ring_we, r_wp != $past(r_wp))

endmodule

`default_nettype wire
